// ===== sv/lkv_pkg.sv =====
// lkv_pkg: shared types and constants for the LRU key-value cache.
// Used by lkv_cell and lru_key_value_cache; no dependencies.
package lkv_pkg;

  localparam int ENTRIES = 16;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int CAP_W   = 5;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int MW      = (CAP_W > CNT_W) ? CAP_W : CNT_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
  localparam logic             ACT_GET   = 1'b0;
  localparam logic             ACT_PUT   = 1'b1;
  localparam logic [VAL_W-1:0] READ_MISS = {VAL_W{1'b1}};
  localparam logic [VAL_W-1:0] READ_PUT  = '0;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic go;
    logic hit;
    logic put;
  } ctl_t;

  typedef enum logic {
    S_IDLE,
    S_UPD
  } state_t;

endpackage

// ===== sv/lkv_cell.sv =====
// lkv_cell: one recency slot of the LRU chain; compares a key and takes
// its upper neighbor's entry on an update. Depends on lkv_pkg.
module lkv_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     clr,
  input  logic                     lk_en,
  input  logic [lkv_pkg::KEY_W-1:0] lk_key,
  input  lkv_pkg::ctl_t            ctl,
  input  logic                     in_cap,
  input  lkv_pkg::entry_t          prev_ent,
  input  logic                     mb_in,
  output lkv_pkg::entry_t          ent,
  output logic                     match,
  output logic                     mb_out
);

  logic                      valid_r;
  logic [lkv_pkg::KEY_W-1:0] key_r;
  logic [lkv_pkg::VAL_W-1:0] value_r;
  logic                      match_r;
  logic                      take;

  // hit: slots above the match shift down; miss put: slots up to the
  // first free one (or the capacity limit) shift down
  assign take = ctl.go && (ctl.hit ? !mb_in : (ctl.put && prev_ent.valid && in_cap));

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= prev_ent.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      key_r   <= prev_ent.key;
      value_r <= prev_ent.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (lk_en) begin
      match_r <= valid_r && (key_r == lk_key);
    end
  end

  assign ent    = {valid_r, key_r, value_r};
  assign match  = match_r;
  assign mb_out = mb_in | match_r;

endmodule

// ===== sv/lru_key_value_cache.sv =====
// Usage: fully associative key-value cache with least-recently-used eviction.
// Input beat: in_tuser = action (0 get, 1 put), in_tdata = key, value.
// Output beat: out_tuser = hit, out_tdata = read_value (get hit: value,
// get miss: all ones, put: zero). One output beat per input beat, in order.
// The key is compared against every slot at the accepting edge; in the
// update state the chain of cells shifts to put the touched entry at the
// head and the output register is loaded. A beat is not accepted while
// the previous one is still in the update state.
// The next beat is taken as soon as the shift is done, even while the
// previous result still waits in the output register. If the receiver
// stalls with a result pending, the shift cycle waits for out_tready.
// Reset empties the store and sets capacity to 16. A cfg_we write loads
// capacity (0 acts as 1, values above the slot count saturate) and empties
// the store; write only while idle.
// Depends on lkv_pkg and lkv_cell.
module lru_key_value_cache (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [lkv_pkg::CAP_W-1:0]  cfg_wdata,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [63:0]                in_tdata,   // key [31:0], value [63:32]
  input  logic [0:0]                 in_tuser,   // action [0]
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [31:0]                out_tdata,  // read_value [31:0]
  output logic [0:0]                 out_tuser   // hit [0]
);

  localparam int N = lkv_pkg::ENTRIES;

  lkv_pkg::state_t state_r, state_nxt;

  logic [lkv_pkg::CAP_W-1:0] cap_r;
  logic [lkv_pkg::MW-1:0]    eff_cap;
  logic [N-1:0]              cap_mask;

  logic                      put_r;
  logic [lkv_pkg::KEY_W-1:0] key_r;
  logic [lkv_pkg::VAL_W-1:0] val_r;

  logic                      out_valid_r, out_valid_nxt;
  logic                      out_hit_r;
  logic [lkv_pkg::VAL_W-1:0] out_data_r;

  logic                      in_acc;
  logic                      go;
  logic                      hit;
  logic [lkv_pkg::VAL_W-1:0] hit_val;
  logic [lkv_pkg::VAL_W-1:0] rd_val;
  lkv_pkg::ctl_t             ctl;
  lkv_pkg::entry_t           head;

  lkv_pkg::entry_t ent  [N];
  lkv_pkg::entry_t prev [N];
  logic [N-1:0]    match;
  logic [N-1:0]    vld;
  logic [N:0]      mb;

  // ---- state machine ----
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lkv_pkg::S_IDLE: if (in_tvalid) state_nxt = lkv_pkg::S_UPD;
      lkv_pkg::S_UPD:  if (!out_valid_r || out_tready) state_nxt = lkv_pkg::S_IDLE;
      default:         state_nxt = lkv_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    go        = 1'b0;
    case (state_r)
      lkv_pkg::S_IDLE: in_tready = 1'b1;
      lkv_pkg::S_UPD:  go = !out_valid_r || out_tready;
      default: begin
        in_tready = 1'b0;
        go        = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lkv_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_acc = in_tvalid && in_tready;

  // ---- capacity ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lkv_pkg::CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (cap_r == '0) begin
      eff_cap = lkv_pkg::MW'(1);
    end else if (lkv_pkg::MW'(cap_r) > lkv_pkg::MW'(N)) begin
      eff_cap = lkv_pkg::MW'(N);
    end else begin
      eff_cap = lkv_pkg::MW'(cap_r);
    end
  end

  // ---- request hold ----
  always_ff @(posedge clk) begin
    if (in_acc) begin
      put_r <= (in_tuser[0] == lkv_pkg::ACT_PUT);
      key_r <= in_tdata[31:0];
      val_r <= in_tdata[63:32];
    end
  end

  // ---- cell chain ----
  assign hit = |match;

  always_comb begin
    hit_val = '0;
    for (int i = 0; i < N; i++) begin
      hit_val = hit_val | (match[i] ? ent[i].value : '0);
    end
  end

  assign ctl.go  = go;
  assign ctl.hit = hit;
  assign ctl.put = put_r;

  assign head.valid = 1'b1;
  assign head.key   = key_r;
  assign head.value = put_r ? val_r : hit_val;

  assign mb[0] = 1'b0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    assign cap_mask[i] = (lkv_pkg::MW'(i) < eff_cap);
    assign vld[i]      = ent[i].valid;

    if (i == 0) begin : g_head
      assign prev[i] = head;
    end else begin : g_link
      assign prev[i] = ent[i-1];
    end

    lkv_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .clr      (cfg_we),
      .lk_en    (in_acc),
      .lk_key   (in_tdata[31:0]),
      .ctl      (ctl),
      .in_cap   (cap_mask[i]),
      .prev_ent (prev[i]),
      .mb_in    (mb[i]),
      .ent      (ent[i]),
      .match    (match[i]),
      .mb_out   (mb[i+1])
    );
  end

  // ---- output register ----
  always_comb begin
    if (put_r) begin
      rd_val = lkv_pkg::READ_PUT;
    end else if (hit) begin
      rd_val = hit_val;
    end else begin
      rd_val = lkv_pkg::READ_MISS;
    end
  end

  always_comb begin
    if (go) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_hit_r  <= hit;
      out_data_r <= rd_val;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_hit_r;

`ifndef SYNTH
  a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lkv_pkg::S_UPD) |-> $onehot0(match))
    else $error("key matched in more than one slot");

  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((vld & (vld + N'(1))) == '0))
    else $error("valid slots are not a prefix of the chain");

  a_occ_cap: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(cfg_we) == 1'b0) |-> (lkv_pkg::MW'($countones(vld)) <= eff_cap))
    else $error("occupancy above capacity");

  a_put_head: assert property (@(posedge clk) disable iff (!rst_n)
    (go && put_r && !cfg_we) |=> vld[0])
    else $error("put left head slot empty");
`endif

endmodule
